// ----- rtl/pls_pkg.sv -----
`default_nettype none
package pls_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 7;
  localparam int CMD_W   = 3;
  localparam int ST_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_DISPLAY   = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_BOUNDS  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_REPORT,
    ACT_INSERT,
    ACT_DELETE,
    ACT_DISPLAY
  } act_t;

  typedef struct packed {
    logic load;
    logic step;
    logic tail;
    logic emit_status;
    logic disp_read;
    logic emit_elem;
  } ctl_cmd_t;

  typedef struct packed {
    act_t act;
    logic at_stop;
    logic disp_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pls_ram.sv -----
`default_nettype none
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pls_ctrl.sv -----
`default_nettype none
module pls_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pls_pkg::dp_stat_t stat,
  output pls_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_TAIL,
    S_RESULT,
    S_DISP_RD,
    S_DISP_WAIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (stat.act)
              pls_pkg::ACT_INSERT,
              pls_pkg::ACT_DELETE:  state <= S_SHIFT;
              pls_pkg::ACT_DISPLAY: state <= S_DISP_RD;
              pls_pkg::ACT_REPORT:  state <= S_RESULT;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_SHIFT: begin
          if (stat.at_stop) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: state <= S_RESULT;
        S_RESULT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_DISP_RD: state <= S_DISP_WAIT;
        S_DISP_WAIT: begin
          if (stat.out_free) begin
            state <= stat.disp_last ? S_IDLE : S_DISP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    cmd.load        = in_ready && in_valid;
    cmd.step        = (state == S_SHIFT);
    cmd.tail        = (state == S_TAIL);
    cmd.emit_status = (state == S_RESULT) && stat.out_free;
    cmd.disp_read   = (state == S_DISP_RD);
    cmd.emit_elem   = (state == S_DISP_WAIT) && stat.out_free;
  end

endmodule
`default_nettype wire

// ----- rtl/pls_dp.sv -----
`default_nettype none
module pls_dp #(
  parameter int CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pls_pkg::ctl_cmd_t             cmd,
  output pls_pkg::dp_stat_t                  stat,
  input  wire logic [pls_pkg::CMD_W-1:0]     in_command,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] in_value,
  input  wire logic [pls_pkg::POS_W-1:0]     in_position,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [pls_pkg::ST_W-1:0]           out_status,
  output logic signed [pls_pkg::VALUE_W-1:0] out_element,
  output logic [pls_pkg::LEN_W-1:0]          out_length,
  output logic                               out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);

  logic [LW-1:0]  len;
  logic [AW-1:0]  cur;
  logic [AW-1:0]  stop;
  logic           dir_ins;
  logic           wr_pend;
  logic [AW-1:0]  wr_dst;
  logic [pls_pkg::VALUE_W-1:0] val_r;
  pls_pkg::status_t st_r;

  logic [8:0] pos9, len9, cap9, pos_m1, len_m1;
  pls_pkg::act_t    dec_act;
  pls_pkg::status_t dec_st;
  logic [8:0]       dec_start, dec_stop;
  logic             dec_ins;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr, src;
  logic [pls_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    pos9      = {1'b0, in_position};
    len9      = 9'(len);
    cap9      = 9'(CAPACITY);
    pos_m1    = pos9 - 9'd1;
    len_m1    = len9 - 9'd1;
    dec_act   = pls_pkg::ACT_NONE;
    dec_st    = pls_pkg::ST_OK;
    dec_start = '0;
    dec_stop  = '0;
    dec_ins   = 1'b0;
    unique case (in_command)
      pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_POS: begin
        if (in_command == pls_pkg::CMD_INS_POS && in_position == '0) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_INVALID;
        end else if (len9 >= cap9) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_FULL;
        end else if (in_command == pls_pkg::CMD_INS_POS && pos9 > len9 + 9'd1) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_BOUNDS;
        end else begin
          dec_act   = pls_pkg::ACT_INSERT;
          dec_ins   = 1'b1;
          dec_start = len9;
          if (in_command == pls_pkg::CMD_INS_FRONT) begin
            dec_stop = '0;
          end else if (in_command == pls_pkg::CMD_INS_BACK) begin
            dec_stop = len9;
          end else begin
            dec_stop = pos_m1;
          end
        end
      end
      pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK: begin
        if (len == '0) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_EMPTY;
        end else begin
          dec_act   = pls_pkg::ACT_DELETE;
          dec_start = (in_command == pls_pkg::CMD_DEL_FRONT) ? 9'd0 : len_m1;
          dec_stop  = len_m1;
        end
      end
      pls_pkg::CMD_DEL_POS: begin
        if (in_position == '0) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_INVALID;
        end else if (pos9 == 9'd1 && len == '0) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_EMPTY;
        end else if (pos9 > len9) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_BOUNDS;
        end else begin
          dec_act   = pls_pkg::ACT_DELETE;
          dec_start = pos_m1;
          dec_stop  = len_m1;
        end
      end
      pls_pkg::CMD_DISPLAY: begin
        if (len == '0) begin
          dec_act = pls_pkg::ACT_REPORT;
          dec_st  = pls_pkg::ST_EMPTY;
        end else begin
          dec_act   = pls_pkg::ACT_DISPLAY;
          dec_start = '0;
          dec_stop  = len_m1;
        end
      end
      default: dec_act = pls_pkg::ACT_NONE;
    endcase
  end

  // copy source: entry below cur when opening a gap, above cur when closing one
  assign src = dir_ins ? (cur - AW'(1)) : (cur + AW'(1));

  always_comb begin
    ram_re    = (cmd.step && (cur != stop)) || cmd.disp_read;
    ram_raddr = cmd.disp_read ? cur : src;
    ram_we    = wr_pend || (cmd.tail && dir_ins);
    ram_waddr = wr_pend ? wr_dst : cur;
    ram_wdata = wr_pend ? ram_rdata : val_r;
  end

  pls_ram #(
    .WIDTH(pls_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        wr_pend <= (cur != stop);
      end
      if (cmd.tail) begin
        len <= dir_ins ? len + LW'(1) : len - LW'(1);
      end
      if (cmd.emit_status || cmd.emit_elem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r   <= in_value;
      st_r    <= dec_st;
      dir_ins <= dec_ins;
      cur     <= AW'(dec_start);
      stop    <= AW'(dec_stop);
    end
    if (cmd.step && (cur != stop)) begin
      wr_dst <= cur;
      cur    <= dir_ins ? cur - AW'(1) : cur + AW'(1);
    end
    if (cmd.emit_status) begin
      out_status  <= st_r;
      out_element <= '0;
      out_length  <= pls_pkg::LEN_W'(len);
      out_last    <= 1'b1;
    end
    if (cmd.emit_elem) begin
      out_status  <= pls_pkg::ST_OK;
      out_element <= ram_rdata;
      out_length  <= pls_pkg::LEN_W'(len);
      out_last    <= (cur == stop);
      cur         <= cur + AW'(1);
    end
  end

  always_comb begin
    stat.act       = dec_act;
    stat.at_stop   = (cur == stop);
    stat.disp_last = (cur == stop);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- rtl/positional_list_store.sv -----
`default_nettype none
// channel   dir  tdata                              tuser       tlast
// s_axis    in   value[31:0], position[39:32]       command     -
// m_axis    out  element[31:0], list_length[38:32]  status      last
//
// One command at a time. A positional insert or delete moving n entries makes one RAM
// copy per cycle. Display reads each element through the registered RAM read port.
// rst clears the length and the output valid flag; stored entries are not cleared.
// A stalled m_axis holds the result; the next command is taken meanwhile.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], position[39:32]
  input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // element[31:0], list_length[38:32], zero
  output logic [2:0]       m_axis_tuser,  // status[2:0]
  output logic             m_axis_tlast
);

  pls_pkg::ctl_cmd_t ctl_cmd;
  pls_pkg::dp_stat_t dp_stat;

  logic [pls_pkg::ST_W-1:0]           out_status;
  logic signed [pls_pkg::VALUE_W-1:0] out_element;
  logic [pls_pkg::LEN_W-1:0]          out_length;

  pls_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (dp_stat),
    .cmd     (ctl_cmd)
  );

  pls_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .stat       (dp_stat),
    .in_command (s_axis_tuser),
    .in_value   (s_axis_tdata[31:0]),
    .in_position(s_axis_tdata[39:32]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_element(out_element),
    .out_length (out_length),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_length, out_element};
  assign m_axis_tuser = out_status;

  a_no_shift_when_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !ctl_cmd.step && !ctl_cmd.tail)
    else $error("list shift active while accepting commands");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctl_cmd.emit_status && ctl_cmd.emit_elem))
    else $error("two result sources in one cycle");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[38:32] <= pls_pkg::LEN_W'(CAPACITY)))
    else $error("reported length exceeds capacity");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != pls_pkg::ST_OK)) |-> m_axis_tlast)
    else $error("failure status without last mark");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int LIST_CAP = 16;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_CMDS = 70;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]         code;
    logic signed [31:0] value;
    logic [7:0]         position;
  } list_cmd_t;

  typedef struct {
    pls_pkg::status_t   status;
    logic signed [31:0] element;
    logic [6:0]         length;
    logic               last;
  } list_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // value[31:0], position[39:32]
  logic [2:0]  s_axis_tuser = '0;  // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // element[31:0], list_length[38:32], zero
  logic [2:0]  m_axis_tuser;       // status[2:0]
  logic        m_axis_tlast;

  list_cmd_t          pending_cmds[$];
  list_beat_t         expected_beats[$];
  logic signed [31:0] stored_values[$];
  list_cmd_t          cmd_on_bus;
  int                 fail_count = 0;
  int                 send_gap = 0;
  int                 send_calm = 0;
  int                 recv_hold = 0;
  int                 recv_calm = 0;
  int                 gen_len = 0;
  int                 random_cmds = 0;

  positional_list_store #(.CAPACITY(LIST_CAP)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Zero gaps come in stretches so back-to-back traffic is covered too.
  function automatic int draw_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 24);
    return $urandom_range(0, 8);
  endfunction

  function automatic void push_beat(pls_pkg::status_t st, logic signed [31:0] elem, logic last);
    list_beat_t b;
    b.status  = st;
    b.element = elem;
    b.length  = 7'(stored_values.size());
    b.last    = last;
    expected_beats.push_back(b);
  endfunction

  function automatic void apply_list_command(list_cmd_t c);
    pls_pkg::status_t st;
    int n;
    n  = stored_values.size();
    st = pls_pkg::ST_OK;
    case (c.code)
      pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_POS: begin
        if (c.code == pls_pkg::CMD_INS_POS && c.position == 0) st = pls_pkg::ST_INVALID;
        else if (n >= LIST_CAP) st = pls_pkg::ST_FULL;
        else if (c.code == pls_pkg::CMD_INS_POS && int'(c.position) > n + 1)
          st = pls_pkg::ST_BOUNDS;
        else if (c.code == pls_pkg::CMD_INS_FRONT) stored_values.push_front(c.value);
        else if (c.code == pls_pkg::CMD_INS_BACK) stored_values.push_back(c.value);
        else stored_values.insert(int'(c.position) - 1, c.value);
      end
      pls_pkg::CMD_DEL_FRONT: begin
        if (n == 0) st = pls_pkg::ST_EMPTY;
        else void'(stored_values.pop_front());
      end
      pls_pkg::CMD_DEL_BACK: begin
        if (n == 0) st = pls_pkg::ST_EMPTY;
        else void'(stored_values.pop_back());
      end
      pls_pkg::CMD_DEL_POS: begin
        if (c.position == 0) st = pls_pkg::ST_INVALID;
        else if (c.position == 1 && n == 0) st = pls_pkg::ST_EMPTY;
        else if (int'(c.position) > n) st = pls_pkg::ST_BOUNDS;
        else stored_values.delete(int'(c.position) - 1);
      end
      pls_pkg::CMD_DISPLAY: begin
        if (n == 0) push_beat(pls_pkg::ST_EMPTY, '0, 1'b1);
        for (int i = 0; i < n; i++) push_beat(pls_pkg::ST_OK, stored_values[i], i == n - 1);
        return;
      end
      default: return;
    endcase
    push_beat(st, '0, 1'b1);
  endfunction

  // queues a command; gen_len follows the list length to steer positions
  task automatic add_cmd(logic [2:0] code, logic signed [31:0] value, logic [7:0] position);
    list_cmd_t c;
    c.code     = code;
    c.value    = value;
    c.position = position;
    pending_cmds.push_back(c);
    case (code)
      pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK:
        if (gen_len < LIST_CAP) gen_len++;
      pls_pkg::CMD_INS_POS:
        if (position != 0 && gen_len < LIST_CAP && int'(position) <= gen_len + 1) gen_len++;
      pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK:
        if (gen_len > 0) gen_len--;
      pls_pkg::CMD_DEL_POS:
        if (position != 0 && int'(position) <= gen_len) gen_len--;
      default: ;
    endcase
    if (code != CMD_UNUSED) random_cmds++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_position(int hi);
    case ($urandom_range(0, 15))
      0: return '0;
      1, 2: return 8'($urandom_range(0, 255));
      3: return 8'(hi + 1);
      default: return 8'($urandom_range(1, hi < 1 ? 1 : hi));
    endcase
  endfunction

  task automatic add_insert();
    case ($urandom_range(0, 2))
      0: add_cmd(pls_pkg::CMD_INS_FRONT, pick_value(), 8'($urandom_range(0, 255)));
      1: add_cmd(pls_pkg::CMD_INS_BACK, pick_value(), 8'($urandom_range(0, 255)));
      default: add_cmd(pls_pkg::CMD_INS_POS, pick_value(), pick_position(gen_len + 1));
    endcase
  endtask

  task automatic add_delete();
    case ($urandom_range(0, 2))
      0: add_cmd(pls_pkg::CMD_DEL_FRONT, $urandom, 8'($urandom_range(0, 255)));
      1: add_cmd(pls_pkg::CMD_DEL_BACK, $urandom, 8'($urandom_range(0, 255)));
      default: add_cmd(pls_pkg::CMD_DEL_POS, $urandom, pick_position(gen_len));
    endcase
  endtask

  always @(posedge clk) begin
    logic busy;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_list_command(cmd_on_bus);
        busy = 1'b0;
        send_gap = draw_gap(send_calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          cmd_on_bus = pending_cmds.pop_front();
          s_axis_tdata <= {cmd_on_bus.position, cmd_on_bus.value};
          s_axis_tuser <= cmd_on_bus.code;
          busy = 1'b1;
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  always @(posedge clk) begin
    logic rdy;
    list_beat_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rdy = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: status %0d element %0d list_length %0d",
                 m_axis_tuser, $signed(m_axis_tdata[31:0]), m_axis_tdata[38:32]);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[31:0] !== want.element) begin
            $error("element: expected %0d, got %0d", want.element,
                   $signed(m_axis_tdata[31:0]));
            fail_count++;
          end
          if (m_axis_tdata[38:32] !== want.length) begin
            $error("list_length: expected %0d, got %0d", want.length, m_axis_tdata[38:32]);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
        end
        rdy = 1'b0;
        recv_hold = draw_gap(recv_calm);
      end
      if (!rdy) begin
        if (recv_hold > 0) recv_hold--;
        else rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin
    int mode;
    int steps;

    add_cmd(pls_pkg::CMD_DISPLAY, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_FRONT, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_BACK, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd0);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd1);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd2);
    add_cmd(pls_pkg::CMD_INS_POS, 32'sd5, 8'd0);
    add_cmd(pls_pkg::CMD_INS_POS, 32'sd6, 8'd2);
    add_cmd(pls_pkg::CMD_INS_FRONT, 32'sh8000_0000, 8'hff);
    add_cmd(pls_pkg::CMD_INS_BACK, 32'sh7fff_ffff, 8'h00);
    add_cmd(pls_pkg::CMD_INS_POS, -32'sd1, 8'd2);
    add_cmd(pls_pkg::CMD_INS_POS, 32'sd0, 8'd4);
    add_cmd(pls_pkg::CMD_INS_POS, 32'sd7, 8'd255);
    add_cmd(pls_pkg::CMD_INS_POS, 32'sh5a5a_a5a5, 8'd1);
    add_cmd(pls_pkg::CMD_DISPLAY, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd255);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd5);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd2);
    add_cmd(CMD_UNUSED, -32'sd1, 8'hff);
    add_cmd(pls_pkg::CMD_DEL_FRONT, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_BACK, '0, '0);
    add_cmd(pls_pkg::CMD_DISPLAY, '0, '0);
    add_cmd(pls_pkg::CMD_DEL_POS, '0, 8'd1);
    add_cmd(pls_pkg::CMD_DISPLAY, '0, '0);

    random_cmds = 0;
    while (random_cmds < RANDOM_CMDS) begin
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
        // fill up, then knock on a full list
        while (gen_len < LIST_CAP) begin
          if ($urandom_range(0, 99) < 85) add_insert();
          else add_delete();
        end
        repeat ($urandom_range(1, 3)) add_insert();
      end else if (mode == 1) begin
        // drain, then poke the empty list
        while (gen_len > 0) begin
          if ($urandom_range(0, 99) < 85) add_delete();
          else add_insert();
        end
        repeat ($urandom_range(1, 3)) add_delete();
      end else begin
        steps = $urandom_range(8, 20);
        repeat (steps) begin
          case ($urandom_range(0, 9))
            0: add_cmd(pls_pkg::CMD_DISPLAY, $urandom, 8'($urandom_range(0, 255)));
            1: add_cmd(CMD_UNUSED, $urandom, 8'($urandom_range(0, 255)));
            2, 3, 4, 5: add_insert();
            default: add_delete();
          endcase
        end
      end
      add_cmd(pls_pkg::CMD_DISPLAY, $urandom, 8'($urandom_range(0, 255)));
    end

    wait (rst == 1'b0);
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/pls_dp.sv
rtl/positional_list_store.sv
tb/sv/testbench.sv
